// ----- sv/crsg_pkg.sv -----
package crsg_pkg;

  localparam int COORD_W   = 32;
  localparam int SPS_W     = 5;
  localparam int SPS_RESET = 10;
  localparam int MAX_SPS   = 31;
  localparam int COEF_W    = 36;
  localparam int TERM_W    = 53;
  localparam int NUM_W     = 56;
  localparam int MAG_W     = 55;
  localparam int DEN_W     = 16;
  localparam int REM_W     = 17;
  localparam int CNT_W     = 6;
  localparam int JOB_DEPTH = 4;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      final_point;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] sample_x;
    logic signed [COORD_W-1:0] sample_y;
    logic                      final_sample;
  } out_item_t;

  typedef enum logic {JOB_SEG, JOB_CLOSE} job_kind_t;

  // px[0] is p0; a closing job carries its point in px[0]/py[0]
  typedef struct packed {
    job_kind_t                 kind;
    logic [3:0][COORD_W-1:0]   px;
    logic [3:0][COORD_W-1:0]   py;
  } job_t;

  typedef enum logic [1:0] {FR_IDLE, FR_SEG_A, FR_SEG_B, FR_CLOSE} front_state_t;
  typedef enum logic [1:0] {BK_IDLE, BK_POLY, BK_DIV, BK_OUT} back_state_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
  } coef_t;

  function automatic logic signed [COEF_W-1:0] ext(input logic [COORD_W-1:0] p);
    return $signed({{(COEF_W-COORD_W){p[COORD_W-1]}}, p});
  endfunction

  // a = 2p0-5p1+4p2-p3, b = -p0+3p1-3p2+p3, c = p2-p0, d = 2p1
  function automatic coef_t coefs(input logic [3:0][COORD_W-1:0] p);
    coef_t r;
    logic signed [COEF_W-1:0] p0, p1, p2, p3;
    p0 = ext(p[0]);
    p1 = ext(p[1]);
    p2 = ext(p[2]);
    p3 = ext(p[3]);
    r.a = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
    r.b = p3 - p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2;
    r.c = p2 - p0;
    r.d = p1 <<< 1;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] sat(input logic [MAG_W-1:0] mag, input logic neg);
    logic [COORD_W-1:0] r;
    if (!neg) begin
      if (|mag[MAG_W-1:COORD_W-1]) r = {1'b0, {(COORD_W-1){1'b1}}};
      else r = mag[COORD_W-1:0];
    end else begin
      if (|mag[MAG_W-1:COORD_W] || (mag[COORD_W-1] && |mag[COORD_W-2:0]))
        r = {1'b1, {(COORD_W-1){1'b0}}};
      else r = -mag[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/crsg_front.sv -----
module crsg_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  crsg_pkg::in_item_t in_item,
  output logic               job_push,
  input  logic               job_full,
  output crsg_pkg::job_t     job_data
);

  crsg_pkg::front_state_t st_r, st_nxt;
  logic [crsg_pkg::COORD_W-1:0] wx_r [3];
  logic [crsg_pkg::COORD_W-1:0] wy_r [3];
  logic [1:0]     cnt_r;
  logic           segb_r;
  crsg_pkg::job_t job_a_r, job_b_r, job_c_r;
  logic           acc;
  logic [crsg_pkg::COORD_W-1:0] qx, qy;

  assign acc = in_push && !in_full;
  assign qx  = in_item.point_x;
  assign qy  = in_item.point_y;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      crsg_pkg::FR_IDLE: begin
        if (acc && cnt_r != 2'd0) begin
          if (cnt_r >= 2'd2) st_nxt = crsg_pkg::FR_SEG_A;
          else if (in_item.final_point) st_nxt = crsg_pkg::FR_SEG_B;
        end
      end
      crsg_pkg::FR_SEG_A: begin
        if (!job_full) st_nxt = segb_r ? crsg_pkg::FR_SEG_B : crsg_pkg::FR_IDLE;
      end
      crsg_pkg::FR_SEG_B: begin
        if (!job_full) st_nxt = crsg_pkg::FR_CLOSE;
      end
      crsg_pkg::FR_CLOSE: begin
        if (!job_full) st_nxt = crsg_pkg::FR_IDLE;
      end
      default: st_nxt = crsg_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_full  = (st_r != crsg_pkg::FR_IDLE);
    job_push = (st_r != crsg_pkg::FR_IDLE) && !job_full;
    case (st_r)
      crsg_pkg::FR_SEG_A: job_data = job_a_r;
      crsg_pkg::FR_SEG_B: job_data = job_b_r;
      default:            job_data = job_c_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= crsg_pkg::FR_IDLE;
      cnt_r <= 2'd0;
    end else begin
      st_r <= st_nxt;
      if (acc) begin
        if (cnt_r == 2'd0) begin
          cnt_r <= in_item.final_point ? 2'd0 : 2'd1;
        end else if (in_item.final_point) begin
          cnt_r <= 2'd0;
        end else if (cnt_r != 2'd3) begin
          cnt_r <= cnt_r + 2'd1;
        end
      end
    end
  end

  // window and pending jobs
  always_ff @(posedge clk) begin
    if (acc) begin
      if (cnt_r == 2'd0) begin
        for (int i = 0; i < 3; i++) begin
          wx_r[i] <= qx;
          wy_r[i] <= qy;
        end
      end else begin
        job_a_r.kind  <= crsg_pkg::JOB_SEG;
        job_a_r.px    <= {qx, wx_r[2], wx_r[1], wx_r[0]};
        job_a_r.py    <= {qy, wy_r[2], wy_r[1], wy_r[0]};
        job_b_r.kind  <= crsg_pkg::JOB_SEG;
        job_b_r.px    <= {qx, qx, wx_r[2], wx_r[1]};
        job_b_r.py    <= {qy, qy, wy_r[2], wy_r[1]};
        job_c_r.kind  <= crsg_pkg::JOB_CLOSE;
        job_c_r.px    <= {qx, qx, qx, qx};
        job_c_r.py    <= {qy, qy, qy, qy};
        segb_r        <= in_item.final_point;
        wx_r[0] <= wx_r[1];
        wy_r[0] <= wy_r[1];
        wx_r[1] <= wx_r[2];
        wy_r[1] <= wy_r[2];
        wx_r[2] <= qx;
        wy_r[2] <= qy;
      end
    end
  end

endmodule

// ----- sv/crsg_job_fifo.sv -----
module crsg_job_fifo #(
  parameter int DEPTH = crsg_pkg::JOB_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  crsg_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output crsg_pkg::job_t pop_data,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  crsg_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;

  assign full     = (cnt_r == (AW+1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wr_r <= (wr_r == AW'(DEPTH-1)) ? '0 : wr_r + AW'(1);
      if (pop && !empty) rd_r <= (rd_r == AW'(DEPTH-1)) ? '0 : rd_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

endmodule

// ----- sv/crsg_back.sv -----
module crsg_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [crsg_pkg::SPS_W-1:0]    sps,
  input  logic                          job_empty,
  input  crsg_pkg::job_t                job_data,
  output logic                          job_pop,
  input  logic                          out_pop,
  output logic                          out_empty,
  output crsg_pkg::out_item_t           out_item
);

  localparam int NW = crsg_pkg::NUM_W;
  localparam int MW = crsg_pkg::MAG_W;
  localparam int DW = crsg_pkg::DEN_W;
  localparam int RW = crsg_pkg::REM_W;

  crsg_pkg::back_state_t st_r, st_nxt;
  crsg_pkg::job_kind_t   kind_r;
  logic [crsg_pkg::SPS_W-1:0] j_r;
  logic [1:0]            step_r;
  logic [crsg_pkg::CNT_W-1:0] cnt_r;
  logic [9:0]            s2_r;
  logic [14:0]           s3_r;
  logic [DW-1:0]         den_r;
  crsg_pkg::coef_t       cx_r, cy_r;
  logic signed [NW-1:0]  ax_r, ay_r;
  logic [RW-2:0]         rx_r, ry_r;
  logic [MW-1:0]         qx_r, qy_r;
  logic                  nx_r, ny_r;
  logic [crsg_pkg::COORD_W-1:0] cpx_r, cpy_r;
  crsg_pkg::out_item_t   out_r;
  logic                  out_valid_r;

  logic                  ld, last_j, div_done;
  logic [15:0]           spow;
  logic signed [NW-1:0]  bx, by, nxt_x, nxt_y;
  logic signed [crsg_pkg::COEF_W-1:0] kx, ky;
  logic signed [NW+5:0]  px_m, py_m;
  logic signed [crsg_pkg::TERM_W-1:0] tx, ty;
  logic [RW-1:0]         shx, shy;
  logic                  bitx, bity;

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;
  assign ld        = !out_valid_r || out_pop;
  assign last_j    = ((j_r + crsg_pkg::SPS_W'(1)) == sps);
  assign div_done  = (cnt_r == crsg_pkg::CNT_W'(MW-1));

  // Horner step: acc = acc*j + coef*s^k
  always_comb begin
    case (step_r)
      2'd0:    begin kx = cx_r.a; ky = cy_r.a; spow = 16'(sps); end
      2'd1:    begin kx = cx_r.c; ky = cy_r.c; spow = 16'(s2_r); end
      default: begin kx = cx_r.d; ky = cy_r.d; spow = 16'(s3_r); end
    endcase
    bx    = (step_r == 2'd0) ? NW'(cx_r.b) : ax_r;
    by    = (step_r == 2'd0) ? NW'(cy_r.b) : ay_r;
    px_m  = bx * $signed({1'b0, j_r});
    py_m  = by * $signed({1'b0, j_r});
    tx    = kx * $signed({1'b0, spow});
    ty    = ky * $signed({1'b0, spow});
    nxt_x = px_m[NW-1:0] + NW'(tx);
    nxt_y = py_m[NW-1:0] + NW'(ty);
  end

  // restoring divide, one quotient bit per cycle
  always_comb begin
    shx  = {rx_r, qx_r[MW-1]};
    shy  = {ry_r, qy_r[MW-1]};
    bitx = (shx >= {1'b0, den_r});
    bity = (shy >= {1'b0, den_r});
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      crsg_pkg::BK_IDLE: begin
        if (!job_empty) begin
          if (job_data.kind == crsg_pkg::JOB_CLOSE) st_nxt = crsg_pkg::BK_OUT;
          else if (sps != '0) st_nxt = crsg_pkg::BK_POLY;
        end
      end
      crsg_pkg::BK_POLY: if (step_r == 2'd3) st_nxt = crsg_pkg::BK_DIV;
      crsg_pkg::BK_DIV:  if (div_done) st_nxt = crsg_pkg::BK_OUT;
      crsg_pkg::BK_OUT: begin
        if (ld) begin
          if (kind_r == crsg_pkg::JOB_CLOSE || last_j) st_nxt = crsg_pkg::BK_IDLE;
          else st_nxt = crsg_pkg::BK_POLY;
        end
      end
      default: st_nxt = crsg_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop = (st_r == crsg_pkg::BK_IDLE) && !job_empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= crsg_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == crsg_pkg::BK_OUT && ld) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      crsg_pkg::BK_IDLE: begin
        if (!job_empty) begin
          kind_r <= job_data.kind;
          cpx_r  <= job_data.px[0];
          cpy_r  <= job_data.py[0];
          cx_r   <= crsg_pkg::coefs(job_data.px);
          cy_r   <= crsg_pkg::coefs(job_data.py);
          s2_r   <= 10'(sps) * 10'(sps);
          s3_r   <= 15'(sps) * 15'(sps) * 15'(sps);
          den_r  <= {15'(sps) * 15'(sps) * 15'(sps), 1'b0};
          j_r    <= '0;
          step_r <= 2'd0;
        end
      end
      crsg_pkg::BK_POLY: begin
        step_r <= step_r + 2'd1;
        if (step_r != 2'd3) begin
          ax_r <= nxt_x;
          ay_r <= nxt_y;
        end else begin
          nx_r  <= ax_r[NW-1];
          ny_r  <= ay_r[NW-1];
          qx_r  <= ax_r[NW-1] ? MW'(-ax_r) : MW'(ax_r);
          qy_r  <= ay_r[NW-1] ? MW'(-ay_r) : MW'(ay_r);
          rx_r  <= '0;
          ry_r  <= '0;
          cnt_r <= '0;
        end
      end
      crsg_pkg::BK_DIV: begin
        cnt_r <= cnt_r + crsg_pkg::CNT_W'(1);
        rx_r  <= bitx ? (RW-1)'(shx - {1'b0, den_r}) : (RW-1)'(shx);
        ry_r  <= bity ? (RW-1)'(shy - {1'b0, den_r}) : (RW-1)'(shy);
        qx_r  <= {qx_r[MW-2:0], bitx};
        qy_r  <= {qy_r[MW-2:0], bity};
      end
      crsg_pkg::BK_OUT: begin
        if (ld) begin
          j_r    <= j_r + crsg_pkg::SPS_W'(1);
          step_r <= 2'd0;
          if (kind_r == crsg_pkg::JOB_CLOSE) begin
            out_r.sample_x     <= cpx_r;
            out_r.sample_y     <= cpy_r;
            out_r.final_sample <= 1'b1;
          end else begin
            out_r.sample_x     <= crsg_pkg::sat(qx_r, nx_r);
            out_r.sample_y     <= crsg_pkg::sat(qy_r, ny_r);
            out_r.final_sample <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_j_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == crsg_pkg::BK_POLY) |-> (j_r < sps))
    else $error("sample index past segment end");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == crsg_pkg::BK_DIV) |-> (cnt_r < crsg_pkg::CNT_W'(MW)))
    else $error("divider overran");
  a_close_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == crsg_pkg::BK_OUT && ld) |=>
      (out_r.final_sample == (kind_r == crsg_pkg::JOB_CLOSE)))
    else $error("final mark does not match job kind");
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == crsg_pkg::BK_DIV) |-> ({1'b0, rx_r} < {1'b0, den_r}))
    else $error("divider remainder out of range");
`endif

endmodule

// ----- sv/catmull_rom_sample_generator_unit.sv -----
// channel | direction | handshake        | payload
// in_     | input     | in_push/in_full  | in_item    (point_x, point_y, final_point)
// out_    | output    | out_pop/out_empty| out_item   (sample_x, sample_y, final_sample)
// cfg_    | input     | cfg_valid/ready  | cfg_data   (samples_per_segment)
//
// Each spline sample takes 3 Horner steps plus a sign/magnitude step, a bit-serial divide
// by 2*S^3, and a load of the output register.
// A segment job is fetched in the idle state; a closing job visits only idle and output.
// The front takes a point while idle, then queues its jobs (up to three), holding while the
// queue is full; the job queue lets the front take the next point while the back still works.
// Synchronous active-low reset clears the point count, job queue and output valid flag;
// samples per segment resets to 10. A stalled output holds the back in its output state.
module catmull_rom_sample_generator_unit #(
  parameter int JOB_DEPTH = crsg_pkg::JOB_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  crsg_pkg::in_item_t         in_item,
  input  logic                       out_pop,
  output logic                       out_empty,
  output crsg_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [crsg_pkg::SPS_W-1:0] cfg_data
);

  logic [crsg_pkg::SPS_W-1:0] sps_r, sps_eff;
  logic           f_push, f_full, b_pop, b_empty;
  crsg_pkg::job_t f_data, b_data;

  assign cfg_ready = 1'b1;
  assign sps_eff   = (sps_r > crsg_pkg::SPS_W'(crsg_pkg::MAX_SPS)) ?
                     crsg_pkg::SPS_W'(crsg_pkg::MAX_SPS) : sps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_r <= crsg_pkg::SPS_W'(crsg_pkg::SPS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      sps_r <= cfg_data;
    end
  end

  crsg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .job_push (f_push),
    .job_full (f_full),
    .job_data (f_data)
  );

  crsg_job_fifo #(.DEPTH(JOB_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_data),
    .full      (f_full),
    .pop       (b_pop),
    .pop_data  (b_data),
    .empty     (b_empty)
  );

  crsg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .sps       (sps_eff),
    .job_empty (b_empty),
    .job_data  (b_data),
    .job_pop   (b_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  crsg_pkg::in_item_t in_item = '0;
  logic out_pop = 1'b0;
  logic out_empty;
  crsg_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [crsg_pkg::SPS_W-1:0] cfg_data = '0;

  // predictor state
  logic signed [crsg_pkg::COORD_W-1:0] win_x [3];
  logic signed [crsg_pkg::COORD_W-1:0] win_y [3];
  int unsigned pts_seen;
  logic [crsg_pkg::SPS_W-1:0] seg_samples;
  crsg_pkg::out_item_t sample_q [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int n_errors = 0;

  always #1 clk = ~clk;

  catmull_rom_sample_generator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_pop(out_pop), .out_empty(out_empty), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic logic [crsg_pkg::COORD_W-1:0] spline_coord(
      longint p0, longint p1, longint p2, longint p3, longint j, longint s);
    longint a, b, num, v;
    a = 2*p0 - 5*p1 + 4*p2 - p3;
    b = -p0 + 3*p1 - 3*p2 + p3;
    num = 2*p1*s*s*s + (p2 - p0)*j*s*s + a*j*j*s + b*j*j*j;
    v = num / (2*s*s*s);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[crsg_pkg::COORD_W-1:0];
  endfunction

  function automatic void add_sample(crsg_pkg::out_item_t r);
    sample_q = {sample_q, r};
  endfunction

  function automatic void push_segment(logic signed [crsg_pkg::COORD_W-1:0] qx,
                                       logic signed [crsg_pkg::COORD_W-1:0] qy);
    crsg_pkg::out_item_t r;
    int s;
    s = int'(seg_samples);
    for (int j = 0; j < s; j++) begin
      r.sample_x = spline_coord(longint'(win_x[0]), longint'(win_x[1]),
                                longint'(win_x[2]), longint'(qx),
                                longint'(j), longint'(s));
      r.sample_y = spline_coord(longint'(win_y[0]), longint'(win_y[1]),
                                longint'(win_y[2]), longint'(qy),
                                longint'(j), longint'(s));
      r.final_sample = 1'b0;
      add_sample(r);
    end
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < 3; i++) begin
      win_x[i] = '0;
      win_y[i] = '0;
    end
    pts_seen = 0;
  endfunction

  function automatic void predict_point(crsg_pkg::in_item_t p);
    crsg_pkg::out_item_t r;
    if (pts_seen == 0) begin
      for (int i = 0; i < 3; i++) begin
        win_x[i] = p.point_x;
        win_y[i] = p.point_y;
      end
      pts_seen = 1;
      if (p.final_point) clear_window();
      return;
    end
    if (pts_seen >= 2) push_segment(p.point_x, p.point_y);
    win_x[0] = win_x[1]; win_y[0] = win_y[1];
    win_x[1] = win_x[2]; win_y[1] = win_y[2];
    win_x[2] = p.point_x; win_y[2] = p.point_y;
    if (pts_seen < 3) pts_seen++;
    if (p.final_point) begin
      // closing window repeats the last point
      push_segment(p.point_x, p.point_y);
      r.sample_x = p.point_x;
      r.sample_y = p.point_y;
      r.final_sample = 1'b1;
      add_sample(r);
      clear_window();
    end
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (sample_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected sample: %h", out_item);
      end else begin
        crsg_pkg::out_item_t e;
        e = sample_q.pop_front();
        if (e !== out_item) begin
          n_errors++;
          if (n_errors <= 10)
            $display("sample mismatch: exp x=%h y=%h f=%b, got x=%h y=%h f=%b",
                     e.sample_x, e.sample_y, e.final_sample,
                     out_item.sample_x, out_item.sample_y, out_item.final_sample);
        end
      end
    end
    out_pop <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_point(logic [crsg_pkg::COORD_W-1:0] x,
                            logic [crsg_pkg::COORD_W-1:0] y, logic fin);
    crsg_pkg::in_item_t p;
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    p.point_x = x;
    p.point_y = y;
    p.final_point = fin;
    in_push <= 1'b1;
    in_item <= p;
    do @(posedge clk); while (in_full);
    predict_point(p);
  endtask

  task automatic stop_sending();
    in_push <= 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    while (sample_q.size() != 0) @(posedge clk);
    // a stored point may still be in flight without any result
    repeat (150) @(posedge clk);
  endtask

  task automatic set_samples(logic [crsg_pkg::SPS_W-1:0] s);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    seg_samples = s;
  endtask

  function automatic logic [crsg_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(4096) - 2048;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_curve(int len);
    for (int i = 0; i < len; i++)
      send_point(rand_coord(), rand_coord(), i == len - 1);
  endtask

  task automatic test_default_rate();
    send_point(32'h00010000, 32'hffff0000, 1'b1);   // single point curve
    send_point(32'h7fffffff, 32'h80000000, 1'b0);
    send_point(32'h80000000, 32'h7fffffff, 1'b1);
    send_point(32'h80000000, 32'h7fffffff, 1'b0);   // overshoot saturates
    send_point(32'h7fffffff, 32'h80000000, 1'b0);
    send_point(32'h80000000, 32'h7fffffff, 1'b0);
    send_point(32'h7fffffff, 32'h80000000, 1'b1);
    send_point(32'h0, 32'h0, 1'b0);
    send_point(32'hffffffff, 32'h00000001, 1'b0);
    send_point(32'h12345678, 32'hedcba987, 1'b1);
  endtask

  task automatic test_zero_samples();
    set_samples(5'd0);
    send_point(32'h00030000, 32'h00050000, 1'b0);
    send_point(32'hfffd0000, 32'h00010000, 1'b0);
    send_point(32'h00020000, 32'h80000000, 1'b1);
    send_point(32'h7fffffff, 32'h7fffffff, 1'b1);
  endtask

  task automatic test_max_samples();
    set_samples(5'd31);
    send_point(32'h80000000, 32'h7fffffff, 1'b0);
    send_point(32'h7fffffff, 32'h80000000, 1'b0);
    send_point(32'h00008000, 32'hffff8000, 1'b1);
    set_samples(5'd1);
    send_point(32'h00010000, 32'h00020000, 1'b0);
    send_point(32'h00040000, 32'h00080000, 1'b1);
  endtask

  task automatic test_random_curves(int n_items, logic [crsg_pkg::SPS_W-1:0] s,
                                    int idle, int stall);
    int sent;
    bit paused;
    set_samples(s);
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    paused = 0;
    while (sent < n_items) begin
      int len;
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(8, 2);
      send_curve(len);
      sent += len;
      if (!paused && sent > n_items / 2) begin
        paused = 1;
        stop_sending();
        while (sample_q.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    clear_window();
    seg_samples = crsg_pkg::SPS_W'(crsg_pkg::SPS_RESET);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_rate();
    test_zero_samples();
    test_max_samples();
    test_random_curves(60, 5'd4, 0, 0);
    test_random_curves(60, 5'd1, 53, 0);
    test_random_curves(35, 5'd31, 0, 53);
    test_random_curves(60, 5'd7, 22, 22);
    test_random_curves(30, crsg_pkg::SPS_W'($urandom_range(31, 1)), 0, 0);
    drain();
    if (n_errors == 0 && sample_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/crsg_pkg.sv
sv/crsg_front.sv
sv/crsg_job_fifo.sv
sv/crsg_back.sv
sv/catmull_rom_sample_generator_unit.sv
tb/tb.sv
